/* design/mpcrc_pkg.sv */
// Shared constants and the one-bit LFSR step for the multi-polynomial CRC block.
package mpcrc_pkg;

  // Data word and CRC register widths
  localparam int DATA_W = 8;
  localparam int CRC_W  = 16;
  localparam int SEL_W  = 3;

  // Polynomial selector codes
  localparam logic [SEL_W-1:0] SEL_CRC5      = 3'd0;
  localparam logic [SEL_W-1:0] SEL_CRC8      = 3'd1;
  localparam logic [SEL_W-1:0] SEL_CRC16     = 3'd2;
  localparam logic [SEL_W-1:0] SEL_CRC16_D0  = 3'd3;
  localparam logic [SEL_W-1:0] SEL_CRC16_T15 = 3'd4;
  localparam logic [SEL_W-1:0] SEL_RESET     = SEL_CRC16;

  // Register masks and tap sets
  localparam logic [CRC_W-1:0] MASK_CRC5  = 16'h001F;
  localparam logic [CRC_W-1:0] MASK_CRC8  = 16'h00FF;
  localparam logic [CRC_W-1:0] MASK_CRC16 = 16'hFFFF;
  localparam logic [CRC_W-1:0] TAPS_CRC5  = 16'h0005;
  localparam logic [CRC_W-1:0] TAPS_CRC8  = 16'h0007;
  localparam logic [CRC_W-1:0] TAPS_CRC16 = 16'h1021;
  localparam logic [CRC_W-1:0] TAPS_T15   = 16'h9021;
  localparam logic [CRC_W-1:0] TAPS_D0TOP = 16'h1020;

  // Register mask for a selector
  function automatic logic [CRC_W-1:0] crc_mask(input logic [SEL_W-1:0] sel);
    logic [CRC_W-1:0] m;
    case (sel)
      SEL_CRC5: m = MASK_CRC5;
      SEL_CRC8: m = MASK_CRC8;
      default:  m = MASK_CRC16;
    endcase
    return m;
  endfunction

  // One serial Galois LFSR step, MSB-first data bit d
  function automatic logic [CRC_W-1:0] lfsr_bit(input logic [CRC_W-1:0] r,
                                                 input logic [SEL_W-1:0] sel,
                                                 input logic d);
    logic [CRC_W-1:0] mask;
    logic [CRC_W-1:0] taps;
    logic [CRC_W-1:0] nxt;
    logic             top;
    logic             fb;
    mask = crc_mask(sel);
    case (sel)
      SEL_CRC5: begin
        top  = r[4];
        taps = TAPS_CRC5;
      end
      SEL_CRC8: begin
        top  = r[7];
        taps = TAPS_CRC8;
      end
      default: begin
        top  = r[15];
        taps = TAPS_CRC16;
      end
    endcase
    fb  = top ^ d;
    nxt = {r[CRC_W-2:0], 1'b0} & mask;
    case (sel)
      SEL_CRC16_D0: begin
        // data enters at bit 0 only; upper taps see the top bit alone
        nxt[0] = nxt[0] ^ fb;
        if (top) nxt = nxt ^ TAPS_D0TOP;
      end
      SEL_CRC16_T15: begin
        if (fb) nxt = nxt ^ TAPS_T15;
      end
      default: begin
        if (fb) nxt = nxt ^ taps;
      end
    endcase
    return nxt & mask;
  endfunction

endpackage

/* design/mpcrc_word_update.sv */
// Combinational word update: restart clear, width mask and DATA_W unrolled LFSR steps.
module mpcrc_word_update import mpcrc_pkg::*; (
  input  logic [CRC_W-1:0]  crc_in,
  input  logic [DATA_W-1:0] data_word,
  input  logic              restart,
  input  logic [SEL_W-1:0]  poly_sel,
  output logic [CRC_W-1:0]  crc_out
);

  logic             sel_valid;
  logic [CRC_W-1:0] start_crc;

  assign sel_valid = (poly_sel == SEL_CRC5) || (poly_sel == SEL_CRC8) ||
                     (poly_sel == SEL_CRC16) || (poly_sel == SEL_CRC16_D0) ||
                     (poly_sel == SEL_CRC16_T15);
  assign start_crc = restart ? '0 : crc_in;

  // Shift the word through the LFSR, MSB first; unused selectors skip the shift
  always_comb begin
    logic [CRC_W-1:0] acc;
    acc = start_crc;
    if (sel_valid) begin
      acc = acc & crc_mask(poly_sel);
      for (int i = DATA_W - 1; i >= 0; i--) begin
        acc = lfsr_bit(acc, poly_sel, data_word[i]);
      end
    end
    crc_out = acc;
  end

endmodule

/* design/multi_poly_crc_word_update.sv */
// Top level: input register, word update logic, result register and CRC state.
// An input transfer is held in the input register, then in the result register.
// Throughput: one word per cycle unless the output stalls; the 8-step XOR
// network between the input and result registers sets the clock period.
// Reset (rst_n low, synchronous): CRC state cleared to zero, selector set to
// CRC-16, pipeline emptied.
module multi_poly_crc_word_update import mpcrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [SEL_W-1:0]  cfg_wr_data,   // poly_select
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,      // [7:0] data_word
  input  logic              in_tuser,      // [0] restart
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CRC_W-1:0]  out_tdata      // [15:0] crc_value
);

  logic [SEL_W-1:0]  poly_sel_r;
  logic              s1_valid_r;
  logic [DATA_W-1:0] s1_data_r;
  logic              s1_restart_r;
  logic              out_valid_r;
  logic [CRC_W-1:0]  out_data_r;
  logic [CRC_W-1:0]  crc_state_r;
  logic [CRC_W-1:0]  crc_nxt;
  logic              in_xfer;
  logic              s1_adv;

  // Stage 1 moves on when the result register is empty or being drained
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_sel_r <= SEL_RESET;
    end else if (cfg_wr_en) begin
      poly_sel_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r    <= in_tdata;
      s1_restart_r <= in_tuser;
    end
  end

  mpcrc_word_update u_word_update (
    .crc_in    (crc_state_r),
    .data_word (s1_data_r),
    .restart   (s1_restart_r),
    .poly_sel  (poly_sel_r),
    .crc_out   (crc_nxt)
  );

  // CRC state follows each word as it leaves stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_state_r <= '0;
    end else if (s1_adv) begin
      crc_state_r <= crc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= crc_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  // A held result is always the current CRC state
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r == crc_state_r))
    else $error("result register differs from CRC state");

  // Full pipeline with a stalled output must refuse input
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while pipeline is full and stalled");

  // State changes only when a word leaves stage 1
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_adv && $past(rst_n)) |=> $stable(crc_state_r))
    else $error("CRC state changed without a word");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");
`endif

endmodule

/* dv/tb_multi_poly_crc_word_update.sv */
// Self-checking testbench for the multi-polynomial CRC word update block.
`timescale 1ns / 1ps

module tb_multi_poly_crc_word_update;
  import mpcrc_pkg::*;

  // Selector codes with no polynomial behind them
  localparam logic [SEL_W-1:0] SEL_UNUSED5 = 3'd5;
  localparam logic [SEL_W-1:0] SEL_UNUSED6 = 3'd6;
  localparam logic [SEL_W-1:0] SEL_UNUSED7 = 3'd7;

  localparam int          SETTLE_CYCLES = 4;       // pipeline is 2 deep
  localparam int          HOLD_CYCLES   = 60;      // long sink hold-off
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int          PHASES        = 10;
  localparam int          PHASE_WORDS   = 40;

  // Directed stimulus row: optional selector write, then one word
  typedef struct packed {
    logic              wr;       // write sel before this word
    logic [SEL_W-1:0]  sel;
    logic [DATA_W-1:0] data;
    logic              restart;
    logic              chk;      // crc below is the typed expectation
    logic [CRC_W-1:0]  crc;
  } word_row_t;

  localparam int DIRECTED_ROWS = 23;
  localparam word_row_t DIRECTED [DIRECTED_ROWS] = '{
    // cleared register with zero data stays zero under CRC-16
    '{1'b0, SEL_CRC16,     8'h00, 1'b1, 1'b1, 16'h0000},
    '{1'b0, SEL_CRC16,     8'h80, 1'b1, 1'b0, 16'h0000},
    '{1'b0, SEL_CRC16,     8'hFF, 1'b0, 1'b0, 16'h0000},
    '{1'b0, SEL_CRC16,     8'h00, 1'b0, 1'b0, 16'h0000},
    // narrowing to CRC-5 drops stale upper bits
    '{1'b1, SEL_CRC5,      8'hFF, 1'b0, 1'b0, 16'h0000},
    '{1'b0, SEL_CRC5,      8'h01, 1'b0, 1'b0, 16'h0000},
    '{1'b0, SEL_CRC5,      8'h00, 1'b1, 1'b1, 16'h0000},
    '{1'b0, SEL_CRC5,      8'hFF, 1'b0, 1'b0, 16'h0000},
    '{1'b1, SEL_CRC8,      8'hFF, 1'b0, 1'b0, 16'h0000},
    '{1'b0, SEL_CRC8,      8'h80, 1'b0, 1'b0, 16'h0000},
    '{1'b1, SEL_CRC16_D0,  8'hA5, 1'b0, 1'b0, 16'h0000},
    '{1'b0, SEL_CRC16_D0,  8'h5A, 1'b0, 1'b0, 16'h0000},
    '{1'b0, SEL_CRC16_D0,  8'hFF, 1'b0, 1'b0, 16'h0000},
    '{1'b1, SEL_CRC16_T15, 8'hFF, 1'b0, 1'b0, 16'h0000},
    '{1'b0, SEL_CRC16_T15, 8'h00, 1'b1, 1'b1, 16'h0000},
    '{1'b0, SEL_CRC16_T15, 8'h80, 1'b0, 1'b0, 16'h0000},
    '{1'b0, SEL_CRC16_T15, 8'h7F, 1'b0, 1'b0, 16'h0000},
    // unused selectors leave the register alone, restart still clears
    '{1'b1, SEL_UNUSED5,   8'hFF, 1'b0, 1'b0, 16'h0000},
    '{1'b0, SEL_UNUSED5,   8'h3C, 1'b1, 1'b1, 16'h0000},
    '{1'b1, SEL_UNUSED7,   8'hAA, 1'b0, 1'b1, 16'h0000},
    '{1'b1, SEL_UNUSED6,   8'h55, 1'b0, 1'b1, 16'h0000},
    '{1'b1, SEL_CRC16,     8'h01, 1'b1, 1'b0, 16'h0000},
    '{1'b0, SEL_CRC16,     8'hFF, 1'b0, 1'b0, 16'h0000}
  };

  localparam logic [SEL_W-1:0] PHASE_SEL [PHASES] = '{
    SEL_CRC5, SEL_CRC16_T15, SEL_CRC8, SEL_CRC16_D0, SEL_CRC16,
    SEL_UNUSED7, SEL_CRC5, SEL_CRC16_T15, SEL_UNUSED5, SEL_CRC16
  };

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [SEL_W-1:0]  cfg_wr_data = '0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata    = '0;
  logic              in_tuser    = 1'b0;   // [0] restart
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [CRC_W-1:0]  out_tdata;            // [15:0] crc_value

  // Typed expectation travels beside the word being offered
  logic              typed_chk   = 1'b0;
  logic [CRC_W-1:0]  typed_crc   = '0;

  logic              hold_req    = 1'b0;
  bit                send_quiet  = 1'b0;

  logic [CRC_W-1:0]  pending_crc_q[$];
  logic [CRC_W-1:0]  crc_state;
  logic [SEL_W-1:0]  poly_sel_shadow;
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count    = 0;

  multi_poly_crc_word_update u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #10 clk = ~clk;

  // CRC register after one word, bit-serial, MSB first
  function automatic logic [CRC_W-1:0] crc_after_word(input logic [CRC_W-1:0]  state,
                                                      input logic [SEL_W-1:0]  sel,
                                                      input logic [DATA_W-1:0] word,
                                                      input logic              restart);
    logic [CRC_W-1:0] r;
    logic [CRC_W-1:0] msk;
    logic [CRC_W-1:0] taps;
    int unsigned      w;
    logic             top;
    logic             fb;
    r = restart ? '0 : state;
    if (sel > SEL_CRC16_T15) return r;
    case (sel)
      SEL_CRC5: begin
        w    = 5;
        taps = TAPS_CRC5;
      end
      SEL_CRC8: begin
        w    = 8;
        taps = TAPS_CRC8;
      end
      SEL_CRC16_T15: begin
        w    = 16;
        taps = TAPS_T15;
      end
      default: begin
        w    = 16;
        taps = TAPS_CRC16;
      end
    endcase
    msk = CRC_W'((32'd1 << w) - 32'd1);
    r   = r & msk;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      top = r[w-1];
      fb  = top ^ word[i];
      r   = (r << 1) & msk;
      if (sel == SEL_CRC16_D0) begin
        // data enters bit 0 only, upper taps follow the top bit
        r[0] = r[0] ^ fb;
        if (top) r = r ^ TAPS_D0TOP;
      end else if (fb) begin
        r = r ^ taps;
      end
    end
    return r;
  endfunction

  // Mostly short idles, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Selector write once the pipeline has drained
  task automatic write_poly(input logic [SEL_W-1:0] sel);
    // let the monitor log a transfer taken at this same edge
    @(posedge clk);
    while (pending_crc_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sel;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Offer one word, wait for its transfer, then maybe idle
  task automatic send_word(input logic [DATA_W-1:0] data, input logic restart,
                           input logic chk, input logic [CRC_W-1:0] crc);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= restart;
    typed_chk <= chk;
    typed_crc <= crc;
    do @(posedge clk); while (!in_tready);
    gap = send_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Track config, predict on input transfers, check output transfers
  always @(posedge clk) begin : crc_monitor
    logic [CRC_W-1:0] want;
    if (!rst_n) begin
      poly_sel_shadow = SEL_CRC16;
      crc_state       = '0;
    end else begin
      if (cfg_wr_en) poly_sel_shadow = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        crc_state = crc_after_word(crc_state, poly_sel_shadow, in_tdata, in_tuser);
        pending_crc_q.push_back(typed_chk ? typed_crc : crc_state);
      end
      if (out_tvalid && out_tready) begin
        if (pending_crc_q.size() == 0) begin
          $display("%0t: unexpected result transfer, crc 0x%04h", $time, out_tdata);
          mismatch_count++;
        end else begin
          want = pending_crc_q.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: crc_value mismatch, expected 0x%04h, actual 0x%04h",
                     $time, want, out_tdata);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Result sink: quiet and noisy stretches, plus one long hold-off on request
  always @(posedge clk) begin : result_sink
    int unsigned stall_left;
    int unsigned phase_left;
    bit          sink_quiet;
    bit          hold_taken;
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      stall_left = HOLD_CYCLES;
    end
    if (phase_left == 0) begin
      sink_quiet = ($urandom_range(0, 3) == 0);
      phase_left = $urandom_range(20, 150);
    end else begin
      phase_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (sink_quiet) begin
      out_tready <= 1'b1;
    end else begin
      stall_left = pick_gap();
      if (stall_left == 0) begin
        out_tready <= 1'b1;
      end else begin
        stall_left--;
        out_tready <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned msg_left;
    logic [DATA_W-1:0] data;
    logic restart;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].wr) begin
        in_tvalid <= 1'b0;
        write_poly(DIRECTED[r].sel);
      end
      send_word(DIRECTED[r].data, DIRECTED[r].restart, DIRECTED[r].chk, DIRECTED[r].crc);
    end

    // random messages: restart opens each, a little noise in between
    msg_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      in_tvalid <= 1'b0;
      write_poly(PHASE_SEL[p]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 2) begin
          // sink holds off while words keep coming, input must stall
          send_quiet = 1'b1;
          if (i == 0) hold_req <= 1'b1;
        end else if (i % 10 == 0) begin
          send_quiet = ($urandom_range(0, 3) == 0);
        end
        if (p == 6 && i == 20) begin
          // sender waits for everything outstanding
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (pending_crc_q.size() != 0) @(posedge clk);
        end
        restart = (msg_left == 0) || ($urandom_range(0, 19) == 0);
        if (msg_left == 0) msg_left = $urandom_range(1, 16);
        msg_left--;
        case ($urandom_range(0, 15))
          0:       data = '0;
          1:       data = '1;
          default: data = DATA_W'($urandom);
        endcase
        send_word(data, restart, 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    // drain
    @(posedge clk);
    while (pending_crc_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
